>>> hw/rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks that a condition holds at every clock edge out of reset.
`define DQ_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Checks that a trigger implies a consequence in the same cycle.
`define DQ_ASSERT_IMP(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) else $error(msg);
// Checks that a trigger implies a consequence in the next cycle.
`define DQ_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);
`else
`define DQ_ASSERT(lbl, cond, msg)
`define DQ_ASSERT_IMP(lbl, trig, cons, msg)
`define DQ_ASSERT_NEXT(lbl, trig, cons, msg)
`endif
`endif

>>> hw/rtl/dq_pkg.sv
// ============================================================================
// Deque package
// Request kinds, status codes and the control word for one storage cell.
// ============================================================================
`timescale 1ns / 1ps

package dq_pkg;

    // Default number of storage cells.
    localparam int DEFAULT_CAPACITY = 16;

    // Width of one stored word.
    localparam int WORD_W = 32;

    // Request kinds carried on the input tuser.
    typedef enum logic [2:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_LIST       = 3'd4
    } kind_t;

    // Result status codes carried on the output tuser.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // What a cell does with its word at each clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_SHR   = 2'd1,
        CELL_SHL   = 2'd2,
        CELL_LOAD  = 2'd3
    } cell_mode_t;

    // Control word handed to every cell.
    typedef struct packed {
        cell_mode_t               mode;
        logic signed [WORD_W-1:0] load_word;
    } cell_ctrl_t;

endpackage

>>> hw/rtl/dq_cell.sv
// ============================================================================
// Deque storage cell
// Holds one word and takes it from a neighbor, a load word, or keeps it.
// ============================================================================
`timescale 1ns / 1ps

module dq_cell (
    input  logic                              clk,
    input  dq_pkg::cell_ctrl_t                ctrl,
    input  logic signed [dq_pkg::WORD_W-1:0]  left_word,   // toward the front
    input  logic signed [dq_pkg::WORD_W-1:0]  right_word,  // toward the back
    output logic signed [dq_pkg::WORD_W-1:0]  word
);

    logic signed [dq_pkg::WORD_W-1:0] word_reg;
    logic signed [dq_pkg::WORD_W-1:0] word_next;

    // Select the new word for this position.
    always_comb
    begin
        unique case (ctrl.mode)
            dq_pkg::CELL_SHR:  word_next = left_word;
            dq_pkg::CELL_SHL:  word_next = right_word;
            dq_pkg::CELL_LOAD: word_next = ctrl.load_word;
            default:           word_next = word_reg;
        endcase
    end

    // Payload register, no reset needed.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

>>> hw/rtl/double_ended_queue.sv
// ============================================================================
// Double-ended queue
// Bounded deque of signed words kept in a row of shifting cells, front first.
// ============================================================================
//
//  Channel  Direction  tdata           tuser         tlast
//  s_axis   in         value[31:0]     kind[2:0]     -
//  m_axis   out        element[31:0]   status[1:0]   final_res
//
//  A push or pop loads its status word into the output register when taken.
//  A listing emits each held word in turn from the front, rotating the cell
//  row one position per emitted word while the output register is free; the
//  input is not ready meanwhile. A new request is taken while the output
//  register is free or being taken. Reset empties the queue at once; cell contents are not cleared.
//
`timescale 1ns / 1ps
`include "assert_macros.svh"

module double_ended_queue #(
    parameter int CAPACITY = dq_pkg::DEFAULT_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic signed [dq_pkg::WORD_W-1:0]  s_axis_tdata,   // value[31:0]
    input  logic [2:0]                        s_axis_tuser,   // kind[2:0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic signed [dq_pkg::WORD_W-1:0]  m_axis_tdata,   // element[31:0]
    output logic [1:0]                        m_axis_tuser,   // status[1:0]
    output logic                              m_axis_tlast    // final_res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LIST = 2'b10
    } state_t;

    state_t                            state_reg, state_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [IDX_W-1:0]                  idx_reg, idx_next;
    logic                              out_valid_reg, out_valid_next;
    logic [1:0]                        out_status_reg, out_status_next;
    logic signed [dq_pkg::WORD_W-1:0]  out_element_reg, out_element_next;
    logic                              out_last_reg, out_last_next;

    logic signed [dq_pkg::WORD_W-1:0]  words [CAPACITY];
    logic                              out_free;
    logic                              accept;
    logic                              list_step;
    logic                              full;
    logic                              empty;
    logic                              do_push_front;
    logic                              do_push_back;
    logic                              do_pop_front;

    // Handshake and queue condition.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign list_step     = (state_reg == ST_LIST) && out_free;
    assign full          = (count_reg == CNT_W'(CAPACITY));
    assign empty         = (count_reg == '0);

    // Operations that move the cell row.
    assign do_push_front = accept && (s_axis_tuser == dq_pkg::KIND_PUSH_FRONT) && !full;
    assign do_push_back  = accept && (s_axis_tuser == dq_pkg::KIND_PUSH_BACK) && !full;
    assign do_pop_front  = accept && (s_axis_tuser == dq_pkg::KIND_POP_FRONT) && !empty;

    // Row of cells; the word at position zero is the front.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        dq_pkg::cell_ctrl_t               ctrl;
        logic signed [dq_pkg::WORD_W-1:0] left_word;
        logic signed [dq_pkg::WORD_W-1:0] right_word;

        if (i == 0) begin : g_first
            assign left_word = s_axis_tdata;
        end else begin : g_inner_left
            assign left_word = words[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_word = words[0];
        end else begin : g_inner_right
            logic is_tail;

            // The last held word takes the front word back while listing.
            assign is_tail    = (count_reg == CNT_W'(i + 1));
            assign right_word = (list_step && is_tail) ? words[0] : words[i+1];
        end

        // Per-cell mode from the shared operation.
        always_comb
        begin
            ctrl.load_word = s_axis_tdata;
            priority if (do_push_front)
                ctrl.mode = dq_pkg::CELL_SHR;
            else if (do_pop_front || list_step)
                ctrl.mode = dq_pkg::CELL_SHL;
            else if (do_push_back && (count_reg == CNT_W'(i)))
                ctrl.mode = dq_pkg::CELL_LOAD;
            else
                ctrl.mode = dq_pkg::CELL_HOLD;
        end

        dq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (words[i])
        );
    end

    // Request handling, listing sequence and output register.
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_status_next  = out_status_reg;
        out_element_next = out_element_reg;
        out_last_next    = out_last_reg;

        if (accept) begin
            out_element_next = '0;
            out_last_next    = 1'b1;
            unique case (s_axis_tuser)
                dq_pkg::KIND_PUSH_FRONT, dq_pkg::KIND_PUSH_BACK:
                begin
                    out_valid_next = 1'b1;
                    if (full) begin
                        out_status_next = dq_pkg::STAT_FULL;
                    end else begin
                        out_status_next = dq_pkg::STAT_OK;
                        count_next      = count_reg + CNT_W'(1);
                    end
                end
                dq_pkg::KIND_POP_FRONT, dq_pkg::KIND_POP_BACK:
                begin
                    out_valid_next = 1'b1;
                    if (empty) begin
                        out_status_next = dq_pkg::STAT_EMPTY;
                    end else begin
                        out_status_next = dq_pkg::STAT_OK;
                        count_next      = count_reg - CNT_W'(1);
                    end
                end
                dq_pkg::KIND_LIST:
                begin
                    if (empty) begin
                        out_valid_next  = 1'b1;
                        out_status_next = dq_pkg::STAT_EMPTY;
                    end else begin
                        state_next = ST_LIST;
                        idx_next   = '0;
                    end
                end
                default:
                begin
                    // Unused kinds are dropped without a result.
                end
            endcase
        end

        // Emit the front word while the row rotates under it.
        if (list_step) begin
            out_valid_next   = 1'b1;
            out_status_next  = dq_pkg::STAT_OK;
            out_element_next = words[0];
            out_last_next    = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));
            idx_next         = idx_reg + IDX_W'(1);
            if (CNT_W'(idx_reg) == count_reg - CNT_W'(1)) begin
                state_next = ST_IDLE;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload registers.
    always_ff @(posedge clk)
    begin
        out_status_reg  <= out_status_next;
        out_element_reg <= out_element_next;
        out_last_reg    <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_element_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    // Checks on the queue bookkeeping and the listing sequence.
    `DQ_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `DQ_ASSERT_IMP(a_list_blocks_input, state_reg == ST_LIST, !s_axis_tready,
                   "input ready while listing")
    `DQ_ASSERT_IMP(a_list_index, state_reg == ST_LIST, CNT_W'(idx_reg) < count_reg,
                   "list index past count")
    `DQ_ASSERT_IMP(a_status_word, out_valid_reg && (out_status_reg != dq_pkg::STAT_OK),
                   (out_element_reg == '0) && out_last_reg, "status word not clean")
    `DQ_ASSERT_NEXT(a_list_start, accept && (s_axis_tuser == dq_pkg::KIND_LIST) && !empty,
                    state_reg == ST_LIST, "listing did not start")

endmodule

>>> dv/testbench.sv
// ============================================================================
// Double-ended queue testbench
// Drives push, pop and listing requests into the deque with random idling on
// both streams, predicts every status and listed word from its own model of
// the queue and checks each result word in order.
// ============================================================================
`timescale 1ns / 1ps

import dq_pkg::*;

// One expected result word.
typedef struct {
    status_t                  status;
    logic signed [WORD_W-1:0] element;
    logic                     last;
} deque_reply_t;

// Keeps its own copy of the queue and the replies still due from the block.
class deque_scoreboard;
    localparam int DEPTH = DEFAULT_CAPACITY;

    logic signed [WORD_W-1:0] cells [DEPTH];
    logic [$clog2(DEPTH)-1:0] head_idx = '0;
    logic [$clog2(DEPTH):0]   fill = '0;
    deque_reply_t             replies_due[$];
    int unsigned              errors = 0;

    function void add_reply(status_t st, logic signed [WORD_W-1:0] el, logic fin);
        deque_reply_t r;
        r.status  = st;
        r.element = el;
        r.last    = fin;
        replies_due.push_back(r);
    endfunction

    // Applies one accepted request to the model and queues its replies.
    function void note_request(logic [2:0] kind, logic signed [WORD_W-1:0] value);
        logic [$clog2(DEPTH)-1:0] slot;
        case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK:
            begin
                if (fill == DEPTH)
                begin
                    add_reply(STAT_FULL, '0, 1'b1);
                end
                else
                begin
                    if (kind == KIND_PUSH_FRONT)
                    begin
                        head_idx = head_idx - 1'b1;
                        slot     = head_idx;
                    end
                    else
                    begin
                        slot = head_idx + fill[$clog2(DEPTH)-1:0];
                    end
                    cells[slot] = value;
                    fill++;
                    add_reply(STAT_OK, '0, 1'b1);
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK:
            begin
                if (fill == 0)
                begin
                    add_reply(STAT_EMPTY, '0, 1'b1);
                end
                else
                begin
                    if (kind == KIND_POP_FRONT)
                    begin
                        head_idx = head_idx + 1'b1;
                    end
                    fill--;
                    add_reply(STAT_OK, '0, 1'b1);
                end
            end
            KIND_LIST:
            begin
                if (fill == 0)
                begin
                    add_reply(STAT_EMPTY, '0, 1'b1);
                end
                else
                begin
                    for (int i = 0; i < fill; i++)
                    begin
                        slot = head_idx + i[$clog2(DEPTH)-1:0];
                        add_reply(STAT_OK, cells[slot], (i + 1 == fill));
                    end
                end
            end
            // Unused kinds are dropped by the block without a reply.
            default:
            begin
            end
        endcase
    endfunction

    // Compares one accepted result word with the oldest reply due.
    function void check_reply(logic [1:0] st, logic signed [WORD_W-1:0] el, logic fin);
        deque_reply_t r;
        if (replies_due.size() == 0)
        begin
            $display("%0t: unexpected word, status %0d element %0d last %0b",
                     $time, st, el, fin);
            errors++;
            return;
        end
        r = replies_due.pop_front();
        if (st !== r.status)
        begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time, r.status, st);
            errors++;
        end
        if (el !== r.element)
        begin
            $display("%0t: element mismatch, expected %0d, actual %0d", $time, r.element, el);
            errors++;
        end
        if (fin !== r.last)
        begin
            $display("%0t: last mismatch, expected %0b, actual %0b", $time, r.last, fin);
            errors++;
        end
    endfunction

    function int pending();
        return replies_due.size();
    endfunction
endclass

module testbench;

    localparam logic [2:0] FIRST_UNUSED_KIND = 3'd5;
    localparam logic [2:0] LAST_UNUSED_KIND  = 3'd7;
    localparam int         RANDOM_REQUESTS   = 85;
    localparam int         LONG_HOLD_CYCLES  = 60;
    localparam int         DRAIN_CYCLES      = 20;
    localparam int         WATCHDOG_LIMIT    = 500;

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic signed [WORD_W-1:0] s_axis_tdata;
    logic [2:0]               s_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic signed [WORD_W-1:0] m_axis_tdata;
    logic [1:0]               m_axis_tuser;
    logic                     m_axis_tlast;

    deque_scoreboard sb = new();

    // Set by the stimulus: no idling at all in the closing stretch.
    bit steady_tail = 1'b0;
    // Set by the stimulus to make the receiver hold off for a long stretch.
    int hold_off_cycles = 0;
    int idle_cycles = 0;

    double_ended_queue i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Records accepted requests and checks accepted result words.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_reply(m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_request(s_axis_tuser, s_axis_tdata);
            end
        end
    end

    // Ends the run when neither stream moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles == WATCHDOG_LIMIT)
                begin
                    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    // Receiver: random short stalls, one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_off_cycles - 1) @(posedge clk);
                hold_off_cycles = 0;
            end
            else if (!steady_tail && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offers one request and returns at the edge where it is taken.
    task automatic send_request(input logic [2:0] kind, input logic signed [WORD_W-1:0] value);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= value;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Sender idles for a random short burst now and then.
    task automatic maybe_pause();
        if (!steady_tail && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Sender stops until every reply due has come back.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
        @(posedge clk);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Growing phases favor pushes so the queue fills, shrinking ones pops.
    function automatic logic [2:0] pick_kind(bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            return 3'($urandom_range(FIRST_UNUSED_KIND, LAST_UNUSED_KIND));
        end
        if (r < 15)
        begin
            return KIND_LIST;
        end
        if (r < (grow ? 75 : 40))
        begin
            return $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        end
        return $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
    endfunction

    initial
    begin
        bit grow;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Empty queue: listing and both pops report empty; an unused kind is dropped.
        send_request(KIND_LIST, $urandom);
        maybe_pause();
        send_request(KIND_POP_FRONT, $urandom);
        send_request(KIND_POP_BACK, $urandom);
        maybe_pause();
        send_request(LAST_UNUSED_KIND, $urandom);
        send_request(KIND_PUSH_FRONT, 32'sh7fff_ffff);
        send_request(KIND_PUSH_BACK, 32'sh8000_0000);

        // Fill to capacity from both ends so the head wraps around.
        for (int i = 0; i < DEFAULT_CAPACITY - 2; i++)
        begin
            send_request((i % 2) ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
                         (i % 4 == 0) ? '0 : (i % 4 == 1) ? '1 : $urandom);
            maybe_pause();
        end

        // Full queue: a push is dropped, the listing gives every word.
        send_request(KIND_PUSH_FRONT, $urandom);
        send_request(KIND_LIST, $urandom);
        send_request(KIND_POP_FRONT, $urandom);
        send_request(KIND_POP_BACK, $urandom);
        send_request(KIND_LIST, $urandom);
        maybe_pause();

        // Random requests in alternating growing and shrinking phases.
        grow = 1'b1;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 12 == 0)
            begin
                grow = $urandom_range(0, 1);
            end
            if (n == 20)
            begin
                hold_off_cycles = LONG_HOLD_CYCLES;
            end
            if (n == 45)
            begin
                wait_for_drain();
            end
            if (n == RANDOM_REQUESTS - 25)
            begin
                steady_tail = 1'b1;
            end
            send_request(pick_kind(grow), pick_value());
            maybe_pause();
        end

        // Let every reply come back, then keep watching for stray words.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
